### sv/mnpl_pkg.sv
// Shared constants and types for the mono note priority list.
package mnpl_pkg;

	// Number of entries in the held-note ring.
	localparam int LIST_SIZE = 16;
	// Width of the held-note count, which must also hold LIST_SIZE itself.
	localparam int CNT_W = $clog2(LIST_SIZE + 1);
	// Width of a MIDI note number or velocity.
	localparam int NOTE_W = 7;

	// Request codes on req_type. The codes above REQ_SET_SINGLE are unused and ignored.
	typedef enum logic [2:0] {
		REQ_NOTE_ON,
		REQ_NOTE_OFF,
		REQ_CLEAR,
		REQ_KEEP_LAST,
		REQ_SET_SINGLE
	} req_t;

	// Action codes of a result transaction.
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_STACCATO,
		ACT_LEGATO_FWD,
		ACT_LEGATO_BACK,
		ACT_MONO_OFF,
		ACT_POLY_OFF
	} action_t;

	// Commands broadcast from the sequencer to every cell of the row.
	typedef struct packed {
		logic insert;   // Shift the row down one cell and load the new note at the top.
		logic tok_load; // Place the search token at the oldest held entry.
		logic tok_clr;  // Remove the search token from the row.
		logic scan;     // Move the search token up by one cell.
		logic capture;  // Mark the cell where the token found the key.
		logic mark_clr; // Drop the mark once it has reached the bottom cell.
		logic bubble;   // Swap the marked cell with the cell below it.
	} mnpl_ctrl_t;

endpackage

### sv/mnpl_cell.sv
// One entry of the held-note row: note, velocity, search token and move mark.
module mnpl_cell
	import mnpl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mnpl_ctrl_t        ctrl,
	input  logic [NOTE_W-1:0] key,
	input  logic [NOTE_W-1:0] up_note,
	input  logic [NOTE_W-1:0] up_vel,
	input  logic [NOTE_W-1:0] dn_note,
	input  logic [NOTE_W-1:0] dn_vel,
	input  logic              tok_in,
	input  logic              tok_start,
	input  logic              mark_up,
	output logic [NOTE_W-1:0] note,
	output logic [NOTE_W-1:0] vel,
	output logic              tok,
	output logic              mark,
	output logic              hit
);

	logic [NOTE_W-1:0] note_q;
	logic [NOTE_W-1:0] vel_q;
	logic              tok_q;
	logic              mark_q;

	assign hit = tok_q && (note_q == key);

	// Entry contents: taken from the cell above on an insert, and swapped with a
	// neighbor while the marked entry travels down.
	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			note_q <= up_note;
			vel_q  <= up_vel;
		end else if (ctrl.bubble) begin
			if (mark_q) begin
				note_q <= dn_note;
				vel_q  <= dn_vel;
			end else if (mark_up) begin
				note_q <= up_note;
				vel_q  <= up_vel;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= 1'b0;
			mark_q <= 1'b0;
		end else begin
			if (ctrl.tok_load) begin
				tok_q <= tok_start;
			end else if (ctrl.tok_clr) begin
				tok_q <= 1'b0;
			end else if (ctrl.scan) begin
				tok_q <= tok_in;
			end

			if (ctrl.capture) begin
				mark_q <= hit;
			end else if (ctrl.mark_clr) begin
				mark_q <= 1'b0;
			end else if (ctrl.bubble) begin
				mark_q <= mark_up;
			end
		end
	end

	assign note = note_q;
	assign vel  = vel_q;
	assign tok  = tok_q;
	assign mark = mark_q;

endmodule

### sv/mono_note_priority_list.sv
// Top level of the last-note-priority held-note list for one monophonic channel.
//
// The held notes live in a row of LIST_SIZE cells kept in ring order, with the
// newest note always in the top cell and the oldest held note in cell LIST_SIZE
// minus the count, counted from the bottom cell. A note on, a set-single-note, a
// clear, a keep-last or an unused request code is handled in the cycle of its
// transaction, and its result then waits in the emit state. A note off sends a search
// token up from the oldest held cell, one cell per cycle, until it meets the key or
// leaves the newest cell without a match (a poly off); a matching entry is then
// swapped down one cell per cycle to the bottom of the row, which closes the gap
// among the held notes. A note off on an empty list needs no walk. One request
// is worked on at a time; the next request transaction is taken as soon as the
// previous result has been handed to the output register, even while that
// result still waits for out_ready. Every request yields exactly one result
// transaction.
module mono_note_priority_list
	import mnpl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [6:0]  key,
	input  logic [6:0]  velocity,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic [6:0]  from_note,
	output logic [6:0]  to_note,
	output logic [6:0]  to_velocity,
	output logic        legato,
	output logic [4:0]  note_count,
	output logic        overflow
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_BUBBLE,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              legato_q;
	logic [NOTE_W-1:0] key_q;
	logic              top_hit_q;

	// Result waiting to move into the output register.
	logic [2:0]        res_action_q;
	logic [NOTE_W-1:0] res_from_q;
	logic [NOTE_W-1:0] res_to_q;
	logic [NOTE_W-1:0] res_vel_q;
	logic              res_ovf_q;

	// Output register.
	logic              out_valid_q;
	logic [2:0]        action_q;
	logic [NOTE_W-1:0] from_note_q;
	logic [NOTE_W-1:0] to_note_q;
	logic [NOTE_W-1:0] to_velocity_q;
	logic              legato_out_q;
	logic [4:0]        note_count_q;
	logic              overflow_q;

	mnpl_ctrl_t ctrl;

	logic [NOTE_W-1:0]    note_vec  [LIST_SIZE];
	logic [NOTE_W-1:0]    vel_vec   [LIST_SIZE];
	logic [NOTE_W-1:0]    up_note   [LIST_SIZE];
	logic [NOTE_W-1:0]    up_vel    [LIST_SIZE];
	logic [NOTE_W-1:0]    dn_note   [LIST_SIZE];
	logic [NOTE_W-1:0]    dn_vel    [LIST_SIZE];
	logic [LIST_SIZE-1:0] tok_vec;
	logic [LIST_SIZE-1:0] tok_in;
	logic [LIST_SIZE-1:0] tok_start;
	logic [LIST_SIZE-1:0] mark_vec;
	logic [LIST_SIZE-1:0] mark_up;
	logic [LIST_SIZE-1:0] hit_vec;

	logic              in_fire;
	logic              emit_fire;
	logic              any_hit;
	logic              cnt_empty;
	logic              cnt_full;
	logic [CNT_W-1:0]  cnt_dec;
	logic [NOTE_W-1:0] top_note;
	logic [NOTE_W-1:0] top_vel;

	// Result and next state for a request taken in the idle state.
	logic [2:0]        idle_action;
	logic [NOTE_W-1:0] idle_from;
	logic [NOTE_W-1:0] idle_to;
	logic [NOTE_W-1:0] idle_vel;
	logic              idle_ovf;
	state_t            idle_next;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign any_hit   = |hit_vec;
	assign cnt_empty = (cnt_q == '0);
	assign cnt_full  = (cnt_q == CNT_W'(LIST_SIZE));
	assign cnt_dec   = cnt_q - CNT_W'(1);
	assign top_note  = note_vec[LIST_SIZE-1];
	assign top_vel   = vel_vec[LIST_SIZE-1];

	// The row of cells. The top cell takes the incoming note on an insert; the
	// bottom cell has nothing below it.
	for (genvar k = 0; k < LIST_SIZE; k++) begin : g_cell
		if (k == LIST_SIZE - 1) begin : g_top
			assign up_note[k] = key;
			assign up_vel[k]  = velocity;
			assign mark_up[k] = 1'b0;
		end else begin : g_upper
			assign up_note[k] = note_vec[k+1];
			assign up_vel[k]  = vel_vec[k+1];
			assign mark_up[k] = mark_vec[k+1];
		end

		if (k == 0) begin : g_bottom
			assign dn_note[k] = '0;
			assign dn_vel[k]  = '0;
			assign tok_in[k]  = 1'b0;
		end else begin : g_lower
			assign dn_note[k] = note_vec[k-1];
			assign dn_vel[k]  = vel_vec[k-1];
			assign tok_in[k]  = tok_vec[k-1];
		end

		// The oldest held note sits at LIST_SIZE minus the count.
		assign tok_start[k] = (cnt_q == CNT_W'(LIST_SIZE - k));

		mnpl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.key       (key_q),
			.up_note   (up_note[k]),
			.up_vel    (up_vel[k]),
			.dn_note   (dn_note[k]),
			.dn_vel    (dn_vel[k]),
			.tok_in    (tok_in[k]),
			.tok_start (tok_start[k]),
			.mark_up   (mark_up[k]),
			.note      (note_vec[k]),
			.vel       (vel_vec[k]),
			.tok       (tok_vec[k]),
			.mark      (mark_vec[k]),
			.hit       (hit_vec[k])
		);
	end

	// Commands to the row.
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (req_type)
						REQ_NOTE_ON, REQ_SET_SINGLE: ctrl.insert = 1'b1;
						REQ_NOTE_OFF: ctrl.tok_load = !cnt_empty;
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (any_hit) begin
					ctrl.capture = 1'b1;
					ctrl.tok_clr = 1'b1;
				end else if (tok_vec[LIST_SIZE-1]) begin
					ctrl.tok_clr = 1'b1;
				end else begin
					ctrl.scan = 1'b1;
				end
			end
			ST_BUBBLE: begin
				if (mark_vec[0]) begin
					ctrl.mark_clr = 1'b1;
				end else begin
					ctrl.bubble = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// A note on answers at once; a note off on an empty list finds nothing, and
	// on a non-empty list it starts the search. Everything else answers with no action.
	always_comb begin
		idle_action = ACT_NONE;
		idle_from   = '0;
		idle_to     = '0;
		idle_vel    = '0;
		idle_ovf    = 1'b0;
		idle_next   = ST_EMIT;
		case (req_type)
			REQ_NOTE_ON: begin
				idle_action = cnt_empty ? ACT_STACCATO : ACT_LEGATO_FWD;
				idle_from   = cnt_empty ? '0 : top_note;
				idle_to     = key;
				idle_vel    = velocity;
				idle_ovf    = cnt_full;
			end
			REQ_NOTE_OFF: begin
				if (cnt_empty) begin
					idle_action = ACT_POLY_OFF;
					idle_to     = key;
				end else begin
					idle_next = ST_SCAN;
				end
			end
			default: ;
		endcase
	end

	// Sequencer, list bookkeeping and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			legato_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						res_action_q <= idle_action;
						res_from_q   <= idle_from;
						res_to_q     <= idle_to;
						res_vel_q    <= idle_vel;
						res_ovf_q    <= idle_ovf;
						key_q        <= key;
						state_q      <= idle_next;
						case (req_type)
							REQ_NOTE_ON: begin
								legato_q <= !cnt_empty;
								if (!cnt_full) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							REQ_CLEAR: begin
								cnt_q    <= '0;
								legato_q <= 1'b0;
							end
							REQ_KEEP_LAST: begin
								if (!cnt_empty) begin
									cnt_q <= CNT_W'(1);
								end
							end
							REQ_SET_SINGLE: begin
								legato_q <= !cnt_empty;
								cnt_q    <= CNT_W'(1);
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (any_hit) begin
						top_hit_q <= hit_vec[LIST_SIZE-1];
						state_q   <= ST_BUBBLE;
					end else if (tok_vec[LIST_SIZE-1]) begin
						// The token left the newest entry without a match.
						res_action_q <= ACT_POLY_OFF;
						res_to_q     <= key_q;
						state_q      <= ST_EMIT;
					end
				end
				ST_BUBBLE: begin
					if (mark_vec[0]) begin
						cnt_q    <= cnt_dec;
						legato_q <= (cnt_dec != '0);
						if (cnt_dec == '0) begin
							res_action_q <= ACT_MONO_OFF;
							res_to_q     <= key_q;
						end else if (top_hit_q) begin
							// The newest note was released: fall back to the one
							// that now sits in the top cell.
							res_action_q <= ACT_LEGATO_BACK;
							res_from_q   <= key_q;
							res_to_q     <= top_note;
							res_vel_q    <= top_vel;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						action_q      <= res_action_q;
						from_note_q   <= res_from_q;
						to_note_q     <= res_to_q;
						to_velocity_q <= res_vel_q;
						legato_out_q  <= legato_q;
						note_count_q  <= 5'(cnt_q);
						overflow_q    <= res_ovf_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign action      = action_q;
	assign from_note   = from_note_q;
	assign to_note     = to_note_q;
	assign to_velocity = to_velocity_q;
	assign legato      = legato_out_q;
	assign note_count  = note_count_q;
	assign overflow    = overflow_q;

endmodule
